// File: rtl/tdim_pkg.sv
// Shared types, codes and constants for the two-channel touch dimmer.
`timescale 1ns / 1ps

package tdim_pkg;

  localparam int TIMER_BITS_DEFAULT = 12;

  localparam int HOLD_W  = 12;
  localparam int STEP_W  = 12;
  localparam int LEVEL_W = 7;
  localparam int SAVED_W = 8;
  localparam int CMP_W   = 10;
  localparam int PWM_W   = 10;
  localparam int VALUE_W = 8;
  localparam int LUX_W   = 16;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam int LEVEL_CAP = 100;
  localparam int LUX_CAP   = 1000;

  // x / 100 as (x * 167773) >> 24, exact for x below 199728 (level * top <= 102300)
  localparam int PWM_SCALE_MULT  = 167773;
  localparam int PWM_SCALE_SHIFT = 24;
  localparam int PWM_SCALE_W     = 28;
  localparam int PROD_W          = PWM_SCALE_W + LEVEL_W;

  // x / 10 as (x * 205) >> 11, exact for x up to 1028
  localparam int LUX_DIV_MULT  = 205;
  localparam int LUX_DIV_SHIFT = 11;
  localparam int LUX_PROD_W    = 18;

  localparam int HOLD_RESET    = 500;
  localparam int STEP_RESET    = 50;
  localparam int MIN_RESET     = 3;
  localparam int MAX_RESET     = 100;
  localparam int PWM_TOP_RESET = 899;
  localparam int LEVEL_RESET   = 3;
  localparam int COMPARE_RESET = LEVEL_RESET * PWM_TOP_RESET / 100;
  localparam longint PWM_SCALE_RESET = longint'(PWM_TOP_RESET) * PWM_SCALE_MULT;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LEVEL  = 2'd1,
    OP_ONOFF  = 2'd2,
    OP_LUX    = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 3'd5;

  typedef struct packed {
    logic [HOLD_W-1:0]      hold_ms;
    logic [STEP_W-1:0]      step_ms;
    logic [LEVEL_W-1:0]     min_level;
    logic [LEVEL_W-1:0]     max_level;
    logic [PWM_SCALE_W-1:0] pwm_scale;
    logic                   auto_enable;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0] lux_target;
    logic               lux_ok;
  } item_t;

  typedef struct packed {
    logic [CMP_W-1:0]   compare;
    logic [LEVEL_W-1:0] level;
    logic               on;
    logic               pressing;
  } chan_view_t;

endpackage

// File: rtl/tdim_level.sv
// Level clamp and percent-to-compare scaling for one channel.
`timescale 1ns / 1ps

module tdim_level (
  input  tdim_pkg::cfg_t                  cfg,
  input  logic signed [8:0]               target,
  output logic [tdim_pkg::LEVEL_W-1:0]    level,
  output logic [tdim_pkg::CMP_W-1:0]      compare
);

  logic signed [8:0]                   clamped;
  logic [tdim_pkg::PROD_W-1:0]         prod;
  logic [tdim_pkg::PROD_W-tdim_pkg::PWM_SCALE_SHIFT-1:0] quot;

  always_comb begin
    clamped = target;
    if (clamped < $signed({2'b00, cfg.min_level})) clamped = $signed({2'b00, cfg.min_level});
    if (clamped > $signed({2'b00, cfg.max_level})) clamped = $signed({2'b00, cfg.max_level});
    if (clamped > 9'sd100) clamped = 9'sd100;
    if (clamped < 9'sd0) clamped = 9'sd0;
    level = clamped[tdim_pkg::LEVEL_W-1:0];
  end

  assign prod = tdim_pkg::PROD_W'(level) * tdim_pkg::PROD_W'(cfg.pwm_scale);
  assign quot = prod[tdim_pkg::PROD_W-1:tdim_pkg::PWM_SCALE_SHIFT];
  assign compare = (quot > 11'd1023) ? 10'd1023 : quot[tdim_pkg::CMP_W-1:0];

endmodule

// File: rtl/tdim_channel.sv
// One dimmer channel: press timing, toggle, stepping and remote updates.
`timescale 1ns / 1ps

module tdim_channel #(
  parameter int TIMER_BITS = tdim_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  tdim_pkg::cfg_t        cfg,
  input  tdim_pkg::item_t       item,
  input  logic                  sel,
  input  logic                  touched,
  output logic                  pressing_now,
  output tdim_pkg::chan_view_t  view_next
);

  localparam int CW = (TIMER_BITS > tdim_pkg::HOLD_W) ? TIMER_BITS : tdim_pkg::HOLD_W;

  logic [tdim_pkg::LEVEL_W-1:0] bright, bright_next;
  logic [tdim_pkg::SAVED_W-1:0] saved, saved_next;
  logic                         on, on_next;
  logic                         pressing, pressing_next;
  logic                         dir, dir_next;
  logic                         flipped, flipped_next;
  logic [TIMER_BITS-1:0]        press_time, press_time_next;
  logic [TIMER_BITS-1:0]        since_step, since_step_next;
  logic [tdim_pkg::CMP_W-1:0]   compare, compare_next;

  logic [TIMER_BITS-1:0]        pt_inc, ss_inc;
  logic                         apply_en;
  logic signed [8:0]            apply_v;
  logic [tdim_pkg::LEVEL_W-1:0] unit_level;
  logic [tdim_pkg::CMP_W-1:0]   unit_compare;

  assign pt_inc = (&press_time) ? press_time : press_time + 1'b1;
  assign ss_inc = (&since_step) ? since_step : since_step + 1'b1;

  tdim_level u_level (
    .cfg     (cfg),
    .target  (apply_v),
    .level   (unit_level),
    .compare (unit_compare)
  );

  always_comb begin
    bright_next     = bright;
    saved_next      = saved;
    on_next         = on;
    pressing_next   = pressing;
    dir_next        = dir;
    flipped_next    = flipped;
    press_time_next = press_time;
    since_step_next = since_step;
    compare_next    = compare;
    apply_en        = 1'b0;
    apply_v         = '0;
    case (item.op)
      tdim_pkg::OP_TICK: begin
        if (touched) begin
          if (!pressing) begin
            pressing_next   = 1'b1;
            press_time_next = '0;
            since_step_next = '0;
            flipped_next    = 1'b0;
          end else begin
            press_time_next = pt_inc;
            since_step_next = ss_inc;
            if (CW'(pt_inc) >= CW'(cfg.hold_ms) && CW'(ss_inc) >= CW'(cfg.step_ms)) begin
              if (!flipped) begin
                dir_next     = !dir;
                flipped_next = 1'b1;
              end
              since_step_next = '0;
              apply_en        = 1'b1;
              apply_v         = dir_next ? $signed({2'b00, bright}) + 9'sd1
                                         : $signed({2'b00, bright}) - 9'sd1;
            end
          end
        end else if (pressing) begin
          // short press toggles
          if (CW'(pt_inc) < CW'(cfg.hold_ms)) begin
            on_next = !on;
            if (on) begin
              saved_next   = {1'b0, bright};
              compare_next = '0;
            end else begin
              apply_en = 1'b1;
              apply_v  = $signed({1'b0, saved});
            end
          end
          pressing_next   = 1'b0;
          press_time_next = '0;
          since_step_next = '0;
          flipped_next    = 1'b0;
        end
      end
      tdim_pkg::OP_LEVEL: begin
        if (sel) begin
          saved_next = item.value;
          if (on) begin
            apply_en = 1'b1;
            apply_v  = $signed({1'b0, item.value});
          end
        end
      end
      tdim_pkg::OP_ONOFF: begin
        if (sel) begin
          on_next = (item.value != '0);
          if (item.value == '0) begin
            saved_next   = {1'b0, bright};
            compare_next = '0;
          end else begin
            apply_en = 1'b1;
            apply_v  = $signed({1'b0, saved});
          end
        end
      end
      tdim_pkg::OP_LUX: begin
        if (item.lux_ok && on) begin
          apply_en = 1'b1;
          apply_v  = $signed({2'b00, item.lux_target});
        end
      end
      default: begin
      end
    endcase
    if (apply_en) begin
      bright_next  = unit_level;
      compare_next = unit_compare;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright     <= tdim_pkg::LEVEL_W'(tdim_pkg::LEVEL_RESET);
      saved      <= tdim_pkg::SAVED_W'(tdim_pkg::LEVEL_RESET);
      on         <= 1'b1;
      pressing   <= 1'b0;
      dir        <= 1'b1;
      flipped    <= 1'b0;
      press_time <= '0;
      since_step <= '0;
      compare    <= tdim_pkg::CMP_W'(tdim_pkg::COMPARE_RESET);
    end else if (advance) begin
      bright     <= bright_next;
      saved      <= saved_next;
      on         <= on_next;
      pressing   <= pressing_next;
      dir        <= dir_next;
      flipped    <= flipped_next;
      press_time <= press_time_next;
      since_step <= since_step_next;
      compare    <= compare_next;
    end
  end

  assign pressing_now       = pressing;
  assign view_next.compare  = compare_next;
  assign view_next.level    = bright_next;
  assign view_next.on       = on_next;
  assign view_next.pressing = pressing_next;

endmodule

// File: rtl/touch_dimmer_two_channel.sv
// Top level of the two-channel touch dimmer: registers, handshake and channel pair.
`timescale 1ns / 1ps

// Takes one request per clock cycle unless stalled, and returns one result per
// request. A request is held in an input register, both channels are updated
// from it in a single pass of clamp, count and a 7 x 28 bit multiply per channel
// for the compare scaling, and the state after the request lands in the result
// register. The result register frees the input side, so a new request is taken
// while a finished result still waits; stall on the result side reaches the input
// side only once both registers are full. Register writes take effect at once.
module touch_dimmer_two_channel #(
  parameter int TIMER_BITS = tdim_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tdim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdim_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      operation,
  input  logic                            channel,
  input  logic                            touch_warm,
  input  logic                            touch_white,
  input  logic [tdim_pkg::VALUE_W-1:0]    value,
  input  logic [tdim_pkg::LUX_W-1:0]      lux,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [tdim_pkg::CMP_W-1:0]      warm_compare,
  output logic [tdim_pkg::CMP_W-1:0]      white_compare,
  output logic [tdim_pkg::LEVEL_W-1:0]    warm_level,
  output logic [tdim_pkg::LEVEL_W-1:0]    white_level,
  output logic                            warm_on,
  output logic                            white_on,
  output logic                            warm_touching,
  output logic                            white_touching
);

  tdim_pkg::cfg_t cfg;

  // input register
  logic                              in_full;
  tdim_pkg::op_t                     in_op;
  logic                              in_channel;
  logic                              in_touch_warm;
  logic                              in_touch_white;
  logic [tdim_pkg::VALUE_W-1:0]      in_value;
  logic [tdim_pkg::LEVEL_W-1:0]      in_lux_target;

  logic                              accept;
  logic                              advance;
  logic [9:0]                        lux_capped;
  logic [tdim_pkg::LUX_PROD_W-1:0]   lux_prod;
  logic [tdim_pkg::LEVEL_W-1:0]      lux_target;

  tdim_pkg::item_t                   item;
  logic                              warm_pressing, white_pressing;
  tdim_pkg::chan_view_t              warm_view, white_view;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ms     <= tdim_pkg::HOLD_W'(tdim_pkg::HOLD_RESET);
      cfg.step_ms     <= tdim_pkg::STEP_W'(tdim_pkg::STEP_RESET);
      cfg.min_level   <= tdim_pkg::LEVEL_W'(tdim_pkg::MIN_RESET);
      cfg.max_level   <= tdim_pkg::LEVEL_W'(tdim_pkg::MAX_RESET);
      cfg.pwm_scale   <= tdim_pkg::PWM_SCALE_W'(tdim_pkg::PWM_SCALE_RESET);
      cfg.auto_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tdim_pkg::CFG_HOLD_MS:     cfg.hold_ms   <= cfg_data[tdim_pkg::HOLD_W-1:0];
        tdim_pkg::CFG_STEP_MS:     cfg.step_ms   <= cfg_data[tdim_pkg::STEP_W-1:0];
        tdim_pkg::CFG_MIN_LEVEL:   cfg.min_level <= cfg_data[tdim_pkg::LEVEL_W-1:0];
        tdim_pkg::CFG_MAX_LEVEL:   cfg.max_level <= cfg_data[tdim_pkg::LEVEL_W-1:0];
        // keep the top pre-multiplied by the reciprocal of 100
        tdim_pkg::CFG_PWM_TOP:     cfg.pwm_scale <=
            tdim_pkg::PWM_SCALE_W'(cfg_data[tdim_pkg::PWM_W-1:0])
          * tdim_pkg::PWM_SCALE_W'(tdim_pkg::PWM_SCALE_MULT);
        tdim_pkg::CFG_AUTO_ENABLE: cfg.auto_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // lux to percent is worked out on the way in
  assign lux_capped = (lux > tdim_pkg::LUX_W'(tdim_pkg::LUX_CAP))
                    ? 10'(tdim_pkg::LUX_CAP) : lux[9:0];
  assign lux_prod   = tdim_pkg::LUX_PROD_W'(lux_capped)
                    * tdim_pkg::LUX_PROD_W'(tdim_pkg::LUX_DIV_MULT);
  assign lux_target = tdim_pkg::LEVEL_W'(tdim_pkg::LEVEL_CAP)
                    - lux_prod[tdim_pkg::LUX_DIV_SHIFT +: tdim_pkg::LEVEL_W];

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op          <= tdim_pkg::op_t'(operation);
      in_channel     <= channel;
      in_touch_warm  <= touch_warm;
      in_touch_white <= touch_white;
      in_value       <= value;
      in_lux_target  <= lux_target;
    end
  end

  assign item.op         = in_op;
  assign item.value      = in_value;
  assign item.lux_target = in_lux_target;
  assign item.lux_ok     = cfg.auto_enable && !warm_pressing && !white_pressing;

  tdim_channel #(.TIMER_BITS(TIMER_BITS)) u_warm (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .item         (item),
    .sel          (!in_channel),
    .touched      (in_touch_warm),
    .pressing_now (warm_pressing),
    .view_next    (warm_view)
  );

  tdim_channel #(.TIMER_BITS(TIMER_BITS)) u_white (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .item         (item),
    .sel          (in_channel),
    .touched      (in_touch_white),
    .pressing_now (white_pressing),
    .view_next    (white_view)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      warm_compare   <= warm_view.compare;
      white_compare  <= white_view.compare;
      warm_level     <= warm_view.level;
      white_level    <= white_view.level;
      warm_on        <= warm_view.on;
      white_on       <= white_view.on;
      warm_touching  <= warm_view.pressing;
      white_touching <= white_view.pressing;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_full && result_valid && result_stall))
    else $error("input stalled with a free stage");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed request left no result");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (warm_level <= 7'd100 && white_level <= 7'd100))
    else $error("brightness above full scale");

  a_no_lux_while_pressing: assert property (@(posedge clk) disable iff (rst)
    (warm_pressing || white_pressing) |-> !item.lux_ok)
    else $error("lux mapping enabled during a press");

endmodule

// File: tb/tb_touch_dimmer_two_channel.sv
// Self-checking testbench for the two-channel touch dimmer: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_touch_dimmer_two_channel;

  localparam int TIMER_TOP      = (1 << tdim_pkg::TIMER_BITS_DEFAULT) - 1;
  localparam int CMP_TOP        = (1 << tdim_pkg::CMP_W) - 1;
  localparam int LUX_PER_PCT    = tdim_pkg::LUX_CAP / tdim_pkg::LEVEL_CAP;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [tdim_pkg::CMP_W-1:0]   warm_cmp;
    logic [tdim_pkg::CMP_W-1:0]   white_cmp;
    logic [tdim_pkg::LEVEL_W-1:0] warm_lvl;
    logic [tdim_pkg::LEVEL_W-1:0] white_lvl;
    logic                         warm_lit;
    logic                         white_lit;
    logic                         warm_held;
    logic                         white_held;
  } dimmer_view_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [tdim_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tdim_pkg::CFG_W-1:0]     cfg_data;
  logic                           item_valid;
  logic                           item_stall;
  logic [1:0]                     operation;
  logic                           channel;
  logic                           touch_warm;
  logic                           touch_white;
  logic [tdim_pkg::VALUE_W-1:0]   value;
  logic [tdim_pkg::LUX_W-1:0]     lux;
  logic                           result_valid;
  logic                           result_stall;
  logic [tdim_pkg::CMP_W-1:0]     warm_compare;
  logic [tdim_pkg::CMP_W-1:0]     white_compare;
  logic [tdim_pkg::LEVEL_W-1:0]   warm_level;
  logic [tdim_pkg::LEVEL_W-1:0]   white_level;
  logic                           warm_on;
  logic                           white_on;
  logic                           warm_touching;
  logic                           white_touching;

  touch_dimmer_two_channel dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .channel        (channel),
    .touch_warm     (touch_warm),
    .touch_white    (touch_white),
    .value          (value),
    .lux            (lux),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .warm_compare   (warm_compare),
    .white_compare  (white_compare),
    .warm_level     (warm_level),
    .white_level    (white_level),
    .warm_on        (warm_on),
    .white_on       (white_on),
    .warm_touching  (warm_touching),
    .white_touching (white_touching)
  );

  // dimmer state as the testbench sees it
  int                           cfg_hold, cfg_step, cfg_min, cfg_max, cfg_top, cfg_auto;
  logic [tdim_pkg::LEVEL_W-1:0] lvl[2];
  logic [tdim_pkg::SAVED_W-1:0] stash[2];
  logic                         lit[2], held[2], upward[2], flipped[2];
  int                           press_ms[2], step_acc[2];
  logic [tdim_pkg::CMP_W-1:0]   cmp[2];

  dimmer_view_t pending_views[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  hold_off_asked = 0;
  int  hold_off_done = 0;
  bit  calm = 1'b0;
  int  touch_left[2];
  int  rest_left[2];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [tdim_pkg::VALUE_W-1:0] rand_value();
    return tdim_pkg::VALUE_W'($urandom);
  endfunction

  function automatic logic [tdim_pkg::LUX_W-1:0] rand_lux();
    return tdim_pkg::LUX_W'($urandom);
  endfunction

  function automatic void reset_model();
    cfg_hold = 500;
    cfg_step = 50;
    cfg_min  = 3;
    cfg_max  = 100;
    cfg_top  = 899;
    cfg_auto = 0;
    for (int c = 0; c < 2; c++) begin
      lvl[c]      = 3;
      stash[c]    = 3;
      lit[c]      = 1'b1;
      held[c]     = 1'b0;
      upward[c]   = 1'b1;
      flipped[c]  = 1'b0;
      press_ms[c] = 0;
      step_acc[c] = 0;
      cmp[c]      = 26;
    end
  endfunction

  // min first, then max, then the 100 % ceiling: min above max ends at max
  function automatic int clamp_pct(int v);
    if (v < cfg_min) v = cfg_min;
    if (v > cfg_max) v = cfg_max;
    if (v > tdim_pkg::LEVEL_CAP) v = tdim_pkg::LEVEL_CAP;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic void set_level(int c, int v);
    int lv;
    int scaled;
    lv     = clamp_pct(v);
    scaled = lv * cfg_top / tdim_pkg::LEVEL_CAP;
    if (scaled > CMP_TOP) scaled = CMP_TOP;
    lvl[c] = lv[tdim_pkg::LEVEL_W-1:0];
    cmp[c] = scaled[tdim_pkg::CMP_W-1:0];
  endfunction

  function automatic void switch_light(int c, logic on);
    lit[c] = on;
    if (!on) begin
      stash[c] = {1'b0, lvl[c]};
      cmp[c]   = '0;
    end else begin
      set_level(c, int'(stash[c]));
    end
  endfunction

  function automatic int sat_inc(int t);
    return (t >= TIMER_TOP) ? TIMER_TOP : t + 1;
  endfunction

  function automatic void tick_pad(int c, logic touched);
    if (touched) begin
      if (!held[c]) begin
        held[c]     = 1'b1;
        press_ms[c] = 0;
        step_acc[c] = 0;
        flipped[c]  = 1'b0;
      end else begin
        press_ms[c] = sat_inc(press_ms[c]);
        step_acc[c] = sat_inc(step_acc[c]);
        if (press_ms[c] >= cfg_hold && step_acc[c] >= cfg_step) begin
          // direction flips once, on the first step of a press
          if (!flipped[c]) begin
            upward[c]  = !upward[c];
            flipped[c] = 1'b1;
          end
          step_acc[c] = 0;
          set_level(c, upward[c] ? int'(lvl[c]) + 1 : int'(lvl[c]) - 1);
        end
      end
    end else if (held[c]) begin
      if (sat_inc(press_ms[c]) < cfg_hold) switch_light(c, !lit[c]);
      held[c]     = 1'b0;
      press_ms[c] = 0;
      step_acc[c] = 0;
      flipped[c]  = 1'b0;
    end
  endfunction

  function automatic dimmer_view_t dimmer_step(tdim_pkg::op_t op, logic ch, logic tw,
                                               logic twh, logic [tdim_pkg::VALUE_W-1:0] val,
                                               logic [tdim_pkg::LUX_W-1:0] lx);
    int target;
    dimmer_view_t view;
    case (op)
      tdim_pkg::OP_TICK: begin
        tick_pad(0, tw);
        tick_pad(1, twh);
      end
      tdim_pkg::OP_LEVEL: begin
        if (lit[ch]) set_level(ch, int'(val));
        stash[ch] = val;
      end
      tdim_pkg::OP_ONOFF: switch_light(ch, val != '0);
      default: begin
        if (cfg_auto != 0 && !held[0] && !held[1]) begin
          target = tdim_pkg::LEVEL_CAP
                 - ((lx > tdim_pkg::LUX_CAP) ? tdim_pkg::LUX_CAP : int'(lx)) / LUX_PER_PCT;
          for (int c = 0; c < 2; c++)
            if (lit[c]) set_level(c, target);
        end
      end
    endcase
    view = '{cmp[0], cmp[1], lvl[0], lvl[1], lit[0], lit[1], held[0], held[1]};
    return view;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int gap_cycles();
    if ($urandom_range(3) != 0) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int press_len();
    int lo;
    int extra;
    case ($urandom_range(2))
      0: return $urandom_range(1, 8);
      1: begin
        // straddles the short/long boundary
        lo = (cfg_hold > 2) ? cfg_hold - 2 : 1;
        return lo + $urandom_range(0, 4);
      end
      default: begin
        extra = cfg_step * $urandom_range(0, 6);
        if (extra > 200) extra = 200;
        return cfg_hold + extra + $urandom_range(0, 2);
      end
    endcase
  endfunction

  function automatic logic next_pad(int c);
    if (touch_left[c] == 0 && rest_left[c] == 0) begin
      touch_left[c] = press_len();
      rest_left[c]  = $urandom_range(1, 8);
    end
    if (touch_left[c] > 0) begin
      touch_left[c]--;
      return 1'b1;
    end
    rest_left[c]--;
    return 1'b0;
  endfunction

  task automatic send_request(input tdim_pkg::op_t op, input logic ch, input logic tw,
                              input logic twh, input logic [tdim_pkg::VALUE_W-1:0] val,
                              input logic [tdim_pkg::LUX_W-1:0] lx);
    int gap;
    gap = calm ? 0 : gap_cycles();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  <= 1'b1;
    operation   <= op;
    channel     <= ch;
    touch_warm  <= tw;
    touch_white <= twh;
    value       <= val;
    lux         <= lx;
    do @(posedge clk); while (item_stall !== 1'b0);
    pending_views.push_back(dimmer_step(op, ch, tw, twh, val, lx));
  endtask

  // drop the request line and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  task automatic program_regs(input int hold, input int step_len, input int lo, input int hi,
                              input int top, input int auto_on);
    int vals[6];
    logic [tdim_pkg::CFG_IDX_W-1:0] regs[6];
    vals = '{hold, step_len, lo, hi, top, auto_on};
    regs = '{tdim_pkg::CFG_HOLD_MS, tdim_pkg::CFG_STEP_MS, tdim_pkg::CFG_MIN_LEVEL,
             tdim_pkg::CFG_MAX_LEVEL, tdim_pkg::CFG_PWM_TOP, tdim_pkg::CFG_AUTO_ENABLE};
    settle();
    foreach (regs[i]) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= tdim_pkg::CFG_W'(vals[i]);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_hold = hold & ((1 << tdim_pkg::HOLD_W) - 1);
    cfg_step = step_len & ((1 << tdim_pkg::STEP_W) - 1);
    cfg_min  = lo & ((1 << tdim_pkg::LEVEL_W) - 1);
    cfg_max  = hi & ((1 << tdim_pkg::LEVEL_W) - 1);
    cfg_top  = top & ((1 << tdim_pkg::PWM_W) - 1);
    cfg_auto = auto_on & 1;
  endtask

  task automatic send_random_item();
    tdim_pkg::op_t op;
    logic [tdim_pkg::VALUE_W-1:0] val;
    logic [tdim_pkg::LUX_W-1:0] lx;
    logic tw, twh;
    val = $urandom_range(1) ? tdim_pkg::VALUE_W'($urandom_range(0, 120)) : rand_value();
    lx  = $urandom_range(1) ? tdim_pkg::LUX_W'($urandom_range(0, 1100)) : rand_lux();
    op  = ($urandom_range(3) == 0) ? tdim_pkg::op_t'($urandom_range(1, 3)) : tdim_pkg::OP_TICK;
    tw  = rand_bit();
    twh = rand_bit();
    // most ticks follow whole presses; the rest are random pad noise
    if (op == tdim_pkg::OP_TICK && $urandom_range(9) != 0) begin
      tw  = next_pad(0);
      twh = next_pad(1);
    end
    send_request(op, rand_bit(), tw, twh, val, lx);
  endtask

  task automatic test_reset_view();
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b0, rand_value(), rand_lux());
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), '0);
  endtask

  task automatic test_remote_commands();
    program_regs(4, 2, 0, 100, 1023, 1);
    send_request(tdim_pkg::OP_LEVEL, 1'b0, rand_bit(), rand_bit(), 8'd255, rand_lux());
    send_request(tdim_pkg::OP_LEVEL, 1'b1, rand_bit(), rand_bit(), 8'd0, rand_lux());
    send_request(tdim_pkg::OP_ONOFF, 1'b0, rand_bit(), rand_bit(), 8'd0, rand_lux());
    send_request(tdim_pkg::OP_ONOFF, 1'b0, rand_bit(), rand_bit(), 8'd0, rand_lux());
    send_request(tdim_pkg::OP_LEVEL, 1'b0, rand_bit(), rand_bit(), 8'd50, rand_lux());
    send_request(tdim_pkg::OP_ONOFF, 1'b0, rand_bit(), rand_bit(), 8'd255, rand_lux());
    send_request(tdim_pkg::OP_ONOFF, 1'b0, rand_bit(), rand_bit(), 8'd1, rand_lux());
    send_request(tdim_pkg::OP_ONOFF, 1'b1, rand_bit(), rand_bit(), 8'd128, rand_lux());
  endtask

  task automatic test_lux_mapping();
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd0);
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'hFFFF);
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd999);
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd1000);
    send_request(tdim_pkg::OP_ONOFF, 1'b1, rand_bit(), rand_bit(), 8'd0, rand_lux());
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd10);
  endtask

  task automatic test_touch_press();
    // both pads long: white is off, yet its compare still follows the steps
    repeat (7)
      send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b1, 1'b1, rand_value(), rand_lux());
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b0, rand_value(), rand_lux());
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b1, rand_value(), rand_lux());
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b0, rand_value(), rand_lux());
    // lux is ignored while a pad is pressed
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b1, 1'b0, rand_value(), rand_lux());
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd300);
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b0, rand_value(), rand_lux());
  endtask

  task automatic test_level_limits();
    program_regs(2, 1, 60, 40, 1, 1);
    send_request(tdim_pkg::OP_ONOFF, 1'b0, rand_bit(), rand_bit(), 8'd7, rand_lux());
    send_request(tdim_pkg::OP_LEVEL, 1'b0, rand_bit(), rand_bit(), 8'd77, rand_lux());
    send_request(tdim_pkg::OP_LEVEL, 1'b1, rand_bit(), rand_bit(), 8'd10, rand_lux());
    send_request(tdim_pkg::OP_LUX, rand_bit(), rand_bit(), rand_bit(), rand_value(), 16'd0);
  endtask

  task automatic test_long_hold();
    program_regs(150, 20, 0, 100, 899, 0);
    calm = 1'b1;
    // warm press runs well past the hold time; white gets random short presses
    repeat (200)
      send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b1, rand_bit(), rand_value(), rand_lux());
    send_request(tdim_pkg::OP_TICK, rand_bit(), 1'b0, 1'b0, rand_value(), rand_lux());
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off_asked++;
    calm = 1'b1;
    repeat (40) send_random_item();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int plan[5][6];
    int quota[5];
    plan  = '{'{6, 2, 3, 100, 899, 1}, '{1, 1, 0, 100, 1023, 1}, '{12, 5, 20, 80, 1, 0},
              '{3, 4095, 100, 0, 512, 1}, '{500, 50, 3, 100, 899, 0}};
    quota = '{200, 150, 200, 150, 300};
    for (int p = 0; p < 5; p++) begin
      program_regs(plan[p][0], plan[p][1], plan[p][2], plan[p][3], plan[p][4], plan[p][5]);
      touch_left = '{0, 0};
      rest_left  = '{0, 0};
      for (int n = 0; n < quota[p]; n++) begin
        if (n % 64 == 0) calm = ($urandom_range(2) == 0);
        if ($urandom_range(149) == 0) settle();
        send_random_item();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    item_valid  = 1'b0;
    operation   = '0;
    channel     = 1'b0;
    touch_warm  = 1'b0;
    touch_white = 1'b0;
    value       = '0;
    lux         = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_view();
    test_remote_commands();
    test_lux_mapping();
    test_touch_press();
    test_level_limits();
    test_backpressure();
    test_long_hold();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stall: random runs, plus one long hold-off on request
  initial begin : result_backpressure
    int left;
    left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_done != hold_off_asked) begin
        hold_off_done = hold_off_asked;
        left = LONG_HOLD;
      end else if (left == 0 && !calm) begin
        left = gap_cycles();
      end
      if (left > 0) begin
        result_stall <= 1'b1;
        left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string field, input logic [tdim_pkg::CMP_W-1:0] want,
                             input logic [tdim_pkg::CMP_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    dimmer_view_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = pending_views.pop_front();
        check_field("warm_compare", want.warm_cmp, warm_compare);
        check_field("white_compare", want.white_cmp, white_compare);
        check_field("warm_level", tdim_pkg::CMP_W'(want.warm_lvl),
                    tdim_pkg::CMP_W'(warm_level));
        check_field("white_level", tdim_pkg::CMP_W'(want.white_lvl),
                    tdim_pkg::CMP_W'(white_level));
        check_field("warm_on", tdim_pkg::CMP_W'(want.warm_lit),
                    tdim_pkg::CMP_W'(warm_on));
        check_field("white_on", tdim_pkg::CMP_W'(want.white_lit),
                    tdim_pkg::CMP_W'(white_on));
        check_field("warm_touching", tdim_pkg::CMP_W'(want.warm_held),
                    tdim_pkg::CMP_W'(warm_touching));
        check_field("white_touching", tdim_pkg::CMP_W'(want.white_held),
                    tdim_pkg::CMP_W'(white_touching));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/tdim_pkg.sv
rtl/tdim_level.sv
rtl/tdim_channel.sv
rtl/touch_dimmer_two_channel.sv
tb/tb_touch_dimmer_two_channel.sv
